>>> rtl/als_pkg.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler package
// Widths, limits, register codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package als_pkg;

    localparam int MAX_STATIONS = 64;
    localparam int SLOT_W       = $clog2(MAX_STATIONS);
    localparam int CNT_W        = $clog2(MAX_STATIONS + 1);

    localparam int TIME_W       = 12;
    localparam int COST_W       = 20;
    localparam int INDEX_W      = 6;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    typedef enum logic [1:0] {
        REG_ENTRY_ONE = 2'd0,
        REG_ENTRY_TWO = 2'd1,
        REG_EXIT_ONE  = 2'd2,
        REG_EXIT_TWO  = 2'd3
    } cfg_reg_t;

    localparam logic [TIME_W-1:0] ENTRY_ONE_RESET = 12'd2;
    localparam logic [TIME_W-1:0] ENTRY_TWO_RESET = 12'd4;
    localparam logic [TIME_W-1:0] EXIT_ONE_RESET  = 12'd3;
    localparam logic [TIME_W-1:0] EXIT_TWO_RESET  = 12'd2;

endpackage

>>> rtl/als_if.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler channels
// Valid/ready channels for station items and for traceback results.
// ----------------------------------------------------------------------------
interface als_station_if import als_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] station_time_one;
    logic [TIME_W-1:0] station_time_two;
    logic [TIME_W-1:0] transfer_from_one;
    logic [TIME_W-1:0] transfer_from_two;
    logic              last_station;

    modport source (
        output valid, station_time_one, station_time_two,
               transfer_from_one, transfer_from_two, last_station,
        input  ready
    );
    modport sink (
        input  valid, station_time_one, station_time_two,
               transfer_from_one, transfer_from_two, last_station,
        output ready
    );
endinterface

interface als_result_if import als_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] station_index;
    logic               line_used;
    logic [COST_W-1:0]  total_cost;
    logic               overflow;
    logic               last_result;

    modport source (
        output valid, station_index, line_used, total_cost, overflow, last_result,
        input  ready
    );
    modport sink (
        input  valid, station_index, line_used, total_cost, overflow, last_result,
        output ready
    );
endinterface

>>> rtl/assembly_line_scheduler.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler
// Two-line assembly line scheduling with per-station traceback.
// ----------------------------------------------------------------------------
// Each transaction on station_in is one station: its times on both lines and
// the transfer costs for leaving it. A small sequencer drives one shared
// saturating adder/comparator. Ready is low while the sequencer works on a
// station, so stations are never taken back to back; the four additions and
// two compares of a later station all go through that one unit. On a station
// marked last_station, EXIT1 and EXIT2 add the exit costs and PICK picks the
// exit line; then READ (the registered memory read) and EMIT (loading the
// result register) walk the came-from memory back one station at a time.
// One result per stored station leaves on result_out, last station first;
// last_result marks station 0, after which the run state is cleared and
// station_in is ready again, even while that result still waits. If
// result_out stalls, the walk waits in place. Reset clears the run state and
// loads the default entry and exit costs; the memory needs no clearing.
// Configuration registers are to be written through the APB port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module assembly_line_scheduler import als_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    als_station_if.sink           station_in,
    als_result_if.source          result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_SW1   = 12'b000000000010,
        ST_MIN1  = 12'b000000000100,
        ST_ADD1  = 12'b000000001000,
        ST_SW2   = 12'b000000010000,
        ST_MIN2  = 12'b000000100000,
        ST_ADD2  = 12'b000001000000,
        ST_EXIT1 = 12'b000010000000,
        ST_EXIT2 = 12'b000100000000,
        ST_PICK  = 12'b001000000000,
        ST_READ  = 12'b010000000000,
        ST_EMIT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [TIME_W-1:0] entry_one_reg, entry_two_reg, exit_one_reg, exit_two_reg;

    // Run state
    logic [COST_W-1:0] best_one_reg, best_two_reg;
    logic [TIME_W-1:0] pend_one_reg, pend_two_reg;
    logic [CNT_W-1:0]  seen_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic              overflow_reg;

    // Working registers of one station
    logic [TIME_W-1:0] time_one_reg, time_two_reg, xfer_one_reg, xfer_two_reg;
    logic              last_reg;
    logic [COST_W-1:0] acc_reg, new_one_reg, new_two_reg;
    logic [1:0]        bits_reg;

    // Traceback
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              line_reg;
    logic [COST_W-1:0] total_reg;
    logic [1:0]        rd_bits_reg;
    logic [1:0]        came_from_mem [MAX_STATIONS];

    // Output register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_line_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic [COST_W-1:0] opa, opb, alu_sum;
    logic              alu_le;
    logic              accept, first_station, emit_go, mem_wr;
    logic [SLOT_W-1:0] slot_inc, slot_dec;

    assign accept        = station_in.valid && station_in.ready;
    assign first_station = (seen_reg == '0);
    assign emit_go       = (state_reg == ST_EMIT) && (!out_valid_reg || result_out.ready);
    assign mem_wr        = (state_reg == ST_ADD2);

    assign slot_inc = (write_slot_reg == SLOT_W'(MAX_STATIONS - 1)) ? '0
                                                                    : write_slot_reg + 1'b1;
    assign slot_dec = (cur_slot_reg == '0) ? SLOT_W'(MAX_STATIONS - 1)
                                           : cur_slot_reg - 1'b1;

    assign station_in.ready = (state_reg == ST_IDLE);

    // Operand selection for the shared unit
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (state_reg)
            ST_SW1:   begin opa = best_two_reg; opb = COST_W'(pend_two_reg);  end
            ST_MIN1:  begin opa = best_one_reg; opb = acc_reg;                end
            ST_ADD1:  begin opa = acc_reg;      opb = COST_W'(time_one_reg);  end
            ST_SW2:   begin opa = best_one_reg; opb = COST_W'(pend_one_reg);  end
            ST_MIN2:  begin opa = best_two_reg; opb = acc_reg;                end
            ST_ADD2:  begin opa = acc_reg;      opb = COST_W'(time_two_reg);  end
            ST_EXIT1: begin opa = best_one_reg; opb = COST_W'(exit_one_reg);  end
            ST_EXIT2: begin opa = best_two_reg; opb = COST_W'(exit_two_reg);  end
            ST_PICK:  begin opa = new_two_reg;  opb = acc_reg;                end
            default:  begin opa = '0;           opb = '0;                     end
        endcase
    end

    als_alu u_alu (
        .opa (opa),
        .opb (opb),
        .sum (alu_sum),
        .le  (alu_le)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = first_station ? ST_ADD1 : ST_SW1;
            ST_SW1:   state_next = ST_MIN1;
            ST_MIN1:  state_next = ST_ADD1;
            ST_ADD1:  state_next = first_station ? ST_ADD2 : ST_SW2;
            ST_SW2:   state_next = ST_MIN2;
            ST_MIN2:  state_next = ST_ADD2;
            ST_ADD2:  state_next = last_reg ? ST_EXIT1 : ST_IDLE;
            ST_EXIT1: state_next = ST_EXIT2;
            ST_EXIT2: state_next = ST_PICK;
            ST_PICK:  state_next = ST_READ;
            ST_READ:  state_next = ST_EMIT;
            ST_EMIT:  if (emit_go) state_next = (pos_reg == '0) ? ST_IDLE : ST_READ;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_one_reg <= ENTRY_ONE_RESET;
            entry_two_reg <= ENTRY_TWO_RESET;
            exit_one_reg  <= EXIT_ONE_RESET;
            exit_two_reg  <= EXIT_TWO_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_reg_t'(paddr[3:2]))
                REG_ENTRY_ONE: entry_one_reg <= pwdata[TIME_W-1:0];
                REG_ENTRY_TWO: entry_two_reg <= pwdata[TIME_W-1:0];
                REG_EXIT_ONE:  exit_one_reg  <= pwdata[TIME_W-1:0];
                REG_EXIT_TWO:  exit_two_reg  <= pwdata[TIME_W-1:0];
                default:       entry_one_reg <= entry_one_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_ENTRY_ONE: prdata = APB_DATA_W'(entry_one_reg);
            REG_ENTRY_TWO: prdata = APB_DATA_W'(entry_two_reg);
            REG_EXIT_ONE:  prdata = APB_DATA_W'(exit_one_reg);
            REG_EXIT_TWO:  prdata = APB_DATA_W'(exit_two_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Run state and traceback control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_one_reg   <= '0;
            best_two_reg   <= '0;
            pend_one_reg   <= '0;
            pend_two_reg   <= '0;
            seen_reg       <= '0;
            write_slot_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (state_reg == ST_ADD2)
        begin
            best_one_reg   <= new_one_reg;
            best_two_reg   <= alu_sum;
            pend_one_reg   <= xfer_one_reg;
            pend_two_reg   <= xfer_two_reg;
            write_slot_reg <= slot_inc;
            if (seen_reg < CNT_W'(MAX_STATIONS))
            begin
                seen_reg <= seen_reg + 1'b1;
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
        else if (emit_go && pos_reg == '0)
        begin
            best_one_reg   <= '0;
            best_two_reg   <= '0;
            pend_one_reg   <= '0;
            pend_two_reg   <= '0;
            seen_reg       <= '0;
            write_slot_reg <= '0;
            overflow_reg   <= 1'b0;
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    time_one_reg <= station_in.station_time_one;
                    time_two_reg <= station_in.station_time_two;
                    xfer_one_reg <= station_in.transfer_from_one;
                    xfer_two_reg <= station_in.transfer_from_two;
                    last_reg     <= station_in.last_station;
                    bits_reg     <= 2'b00;
                    acc_reg      <= COST_W'(entry_one_reg);
                end
            end
            ST_SW1:  acc_reg <= alu_sum;
            ST_MIN1:
            begin
                // A tie keeps the current line.
                if (alu_le)
                begin
                    acc_reg <= best_one_reg;
                end
                else
                begin
                    bits_reg[0] <= 1'b1;
                end
            end
            ST_ADD1:
            begin
                new_one_reg <= alu_sum;
                if (first_station)
                begin
                    acc_reg <= COST_W'(entry_two_reg);
                end
            end
            ST_SW2:  acc_reg <= alu_sum;
            ST_MIN2:
            begin
                if (alu_le)
                begin
                    acc_reg <= best_two_reg;
                end
                else
                begin
                    bits_reg[1] <= 1'b1;
                end
            end
            ST_ADD2:
            begin
                cur_slot_reg <= write_slot_reg;
            end
            ST_EXIT1: acc_reg     <= alu_sum;
            ST_EXIT2: new_two_reg <= alu_sum;
            ST_PICK:
            begin
                // Exit on line two unless line one is strictly cheaper.
                line_reg  <= alu_le;
                total_reg <= alu_le ? new_two_reg : acc_reg;
                pos_reg   <= SLOT_W'(seen_reg - 1'b1);
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    line_reg     <= line_reg ? !rd_bits_reg[1] : rd_bits_reg[0];
                    cur_slot_reg <= slot_dec;
                    pos_reg      <= pos_reg - 1'b1;
                end
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    // Came-from memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            came_from_mem[write_slot_reg] <= bits_reg;
        end
        rd_bits_reg <= came_from_mem[cur_slot_reg];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_index_reg <= INDEX_W'(pos_reg);
            out_line_reg  <= line_reg;
            out_cost_reg  <= total_reg;
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= (pos_reg == '0);
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.station_index = out_index_reg;
    assign result_out.line_used     = out_line_reg;
    assign result_out.total_cost    = out_cost_reg;
    assign result_out.overflow      = out_ovf_reg;
    assign result_out.last_result   = out_last_reg;

endmodule

>>> rtl/als_alu.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler arithmetic unit
// Saturating cost adder and less-or-equal compare, shared by every step.
// ----------------------------------------------------------------------------
module als_alu import als_pkg::*; (
    input  logic [COST_W-1:0] opa,
    input  logic [COST_W-1:0] opb,
    output logic [COST_W-1:0] sum,
    output logic              le
);

    logic [COST_W:0] wide_sum;

    assign wide_sum = {1'b0, opa} + {1'b0, opb};
    assign sum      = wide_sum[COST_W] ? COST_MAX : wide_sum[COST_W-1:0];
    assign le       = (opa <= opb);

endmodule

>>> rtl/als_checker.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler checker
// Port-level assertions on the station and result channels.
// ----------------------------------------------------------------------------
module als_sva import als_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [INDEX_W-1:0] out_index,
    input  logic [COST_W-1:0]  out_cost,
    input  logic               out_last
);

    // Stations are never accepted back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("station accepted in back-to-back cycles");

    // While a run is still being traced back, no new station is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("ready raised in the middle of a traceback");

    // The run ends on the first station.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_index == '0)
        else $error("final result not for station zero");

    // A stalled result keeps its cost.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_cost))
        else $error("stalled result changed");

endmodule

bind assembly_line_scheduler als_sva u_als_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (station_in.valid),
    .in_ready  (station_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_index (result_out.station_index),
    .out_cost  (result_out.total_cost),
    .out_last  (result_out.last_result)
);

>>> tb/als_checker.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler checker
// Watches the station, result and register ports, predicts the traceback of
// every run and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module als_checker import als_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    als_station_if                station_mon,
    als_result_if                 result_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    error_count,
    output int                    results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [INDEX_W-1:0] station_index;
        logic               line_used;
        logic [COST_W-1:0]  total_cost;
        logic               overflow;
        logic               last_result;
    } path_entry_t;

    path_entry_t       path_expected[$];
    path_entry_t       path_seen;

    logic [TIME_W-1:0] entry_one;
    logic [TIME_W-1:0] entry_two;
    logic [TIME_W-1:0] exit_one;
    logic [TIME_W-1:0] exit_two;

    logic [COST_W-1:0] cost_one;
    logic [COST_W-1:0] cost_two;
    logic [TIME_W-1:0] carry_one;
    logic [TIME_W-1:0] carry_two;
    logic [1:0]        came_from [MAX_STATIONS];
    int                stations_count;
    int                ring_slot;
    logic              window_overflow;

    function automatic logic [COST_W-1:0] sat_sum(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    task automatic clear_run();
        cost_one        = '0;
        cost_two        = '0;
        carry_one       = '0;
        carry_two       = '0;
        stations_count  = 0;
        ring_slot       = 0;
        window_overflow = 1'b0;
    endtask

    task automatic write_cost_reg(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        case (cfg_reg_t'(addr[3:2]))
            REG_ENTRY_ONE: entry_one = data[TIME_W-1:0];
            REG_ENTRY_TWO: entry_two = data[TIME_W-1:0];
            REG_EXIT_ONE:  exit_one  = data[TIME_W-1:0];
            REG_EXIT_TWO:  exit_two  = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // One forward step of the two-line recurrence; on the final station the
    // exit line is chosen and the stored came-from bits are walked back.
    task automatic schedule_station(input logic [TIME_W-1:0] t_one,
                                    input logic [TIME_W-1:0] t_two,
                                    input logic [TIME_W-1:0] x_one,
                                    input logic [TIME_W-1:0] x_two,
                                    input logic              last);
        logic [COST_W-1:0] next_one;
        logic [COST_W-1:0] next_two;
        logic [COST_W-1:0] via_one;
        logic [COST_W-1:0] via_two;
        logic [COST_W-1:0] leave_one;
        logic [COST_W-1:0] leave_two;
        logic [COST_W-1:0] total;
        logic [1:0]        from_bits;
        logic              line;
        int                slot;
        int                count;
        int                k;
        int                pos;
        path_entry_t       entry;

        from_bits = 2'b00;
        if (stations_count == 0 && !window_overflow) begin
            next_one = sat_sum(COST_W'(entry_one), COST_W'(t_one));
            next_two = sat_sum(COST_W'(entry_two), COST_W'(t_two));
        end
        else begin
            via_one = sat_sum(cost_two, COST_W'(carry_two));
            via_two = sat_sum(cost_one, COST_W'(carry_one));
            if (cost_one <= via_one) begin
                next_one = sat_sum(cost_one, COST_W'(t_one));
            end
            else begin
                next_one     = sat_sum(via_one, COST_W'(t_one));
                from_bits[0] = 1'b1;
            end
            if (cost_two <= via_two) begin
                next_two = sat_sum(cost_two, COST_W'(t_two));
            end
            else begin
                next_two     = sat_sum(via_two, COST_W'(t_two));
                from_bits[1] = 1'b1;
            end
        end

        slot            = ring_slot;
        came_from[slot] = from_bits;
        ring_slot       = (slot + 1 >= MAX_STATIONS) ? 0 : slot + 1;
        if (stations_count < MAX_STATIONS)
            stations_count++;
        else
            window_overflow = 1'b1;

        cost_one  = next_one;
        cost_two  = next_two;
        carry_one = x_one;
        carry_two = x_two;

        if (last) begin
            leave_one = sat_sum(next_one, COST_W'(exit_one));
            leave_two = sat_sum(next_two, COST_W'(exit_two));
            // A tie at the exit goes to line two.
            if (leave_one < leave_two) begin
                line  = 1'b0;
                total = leave_one;
            end
            else begin
                line  = 1'b1;
                total = leave_two;
            end
            count = stations_count;
            for (k = 0; k < count; k++) begin
                pos                 = count - 1 - k;
                entry.station_index = INDEX_W'(pos);
                entry.line_used     = line;
                entry.total_cost    = total;
                entry.overflow      = window_overflow;
                entry.last_result   = (pos == 0);
                path_expected.push_back(entry);
                if (!line && came_from[slot][0])
                    line = 1'b1;
                else if (line && came_from[slot][1])
                    line = 1'b0;
                slot = (slot == 0) ? MAX_STATIONS - 1 : slot - 1;
            end
            clear_run();
        end
    endtask

    task automatic check_result();
        path_entry_t want;
        path_seen.station_index = result_mon.station_index;
        path_seen.line_used     = result_mon.line_used;
        path_seen.total_cost    = result_mon.total_cost;
        path_seen.overflow      = result_mon.overflow;
        path_seen.last_result   = result_mon.last_result;
        if (path_expected.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display({"%0t: result with none expected: index %0d line %0d",
                          " cost %0d ovf %0b last %0b"},
                         $realtime, path_seen.station_index, path_seen.line_used,
                         path_seen.total_cost, path_seen.overflow, path_seen.last_result);
        end
        else begin
            want = path_expected.pop_front();
            if (path_seen.station_index !== want.station_index ||
                path_seen.line_used     !== want.line_used     ||
                path_seen.total_cost    !== want.total_cost    ||
                path_seen.overflow      !== want.overflow      ||
                path_seen.last_result   !== want.last_result) begin
                error_count++;
                if (error_count <= 10)
                    $display({"%0t: result mismatch: expected index %0d line %0d cost %0d",
                              " ovf %0b last %0b, got index %0d line %0d cost %0d",
                              " ovf %0b last %0b"},
                             $realtime, want.station_index, want.line_used, want.total_cost,
                             want.overflow, want.last_result, path_seen.station_index,
                             path_seen.line_used, path_seen.total_cost, path_seen.overflow,
                             path_seen.last_result);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            entry_one   = ENTRY_ONE_RESET;
            entry_two   = ENTRY_TWO_RESET;
            exit_one    = EXIT_ONE_RESET;
            exit_two    = EXIT_TWO_RESET;
            clear_run();
            path_expected.delete();
            error_count = 0;
            results_due = 0;
        end
        else begin
            if (psel && penable && pwrite && pready)
                write_cost_reg(paddr, pwdata);
            if (station_mon.valid && station_mon.ready)
                schedule_station(station_mon.station_time_one, station_mon.station_time_two,
                                 station_mon.transfer_from_one, station_mon.transfer_from_two,
                                 station_mon.last_station);
            if (result_mon.valid && result_mon.ready)
                check_result();
            results_due = path_expected.size();
        end
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Assembly line scheduler testbench
// Drives station runs under several entry and exit cost settings, with bursty
// input, a stalling result port and one long result hold-off, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench import als_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME,
        MIX_HIGH
    } value_mix_t;

    typedef struct {
        logic [TIME_W-1:0] time_one;
        logic [TIME_W-1:0] time_two;
        logic [TIME_W-1:0] xfer_one;
        logic [TIME_W-1:0] xfer_two;
        logic              last;
    } station_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    error_count;
    int                    results_due;
    int                    cycle_count;
    bit                    hold_off_request;
    station_item_t         station_plan[$];

    als_station_if station_ch ();
    als_result_if  result_ch ();

    assembly_line_scheduler u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .station_in (station_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    als_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .station_mon (station_ch),
        .result_mon  (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .error_count (error_count),
        .results_due (results_due)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] pick_value(input value_mix_t mix);
        case (mix)
            MIX_SMALL:   return TIME_W'($urandom_range(0, 15));
            MIX_EXTREME: return $urandom_range(0, 1) ? TIME_MAX : '0;
            MIX_HIGH:    return TIME_W'($urandom_range(4064, 4095));
            default:     return TIME_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic push_station(input logic [TIME_W-1:0] t_one, input logic [TIME_W-1:0] t_two,
                                input logic [TIME_W-1:0] x_one, input logic [TIME_W-1:0] x_two,
                                input logic last);
        station_item_t item;
        item.time_one = t_one;
        item.time_two = t_two;
        item.xfer_one = x_one;
        item.xfer_two = x_two;
        item.last     = last;
        station_plan.push_back(item);
    endtask

    task automatic plan_run(input int count, input value_mix_t mix);
        int i;
        for (i = 0; i < count; i++)
            push_station(pick_value(mix), pick_value(mix), pick_value(mix), pick_value(mix),
                         i == count - 1);
    endtask

    task automatic apb_write(input cfg_reg_t sel, input logic [TIME_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        // Upper data bits are noise; only the low twelve bits are kept.
        pwdata  <= {(APB_DATA_W - TIME_W)'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_costs(input logic [TIME_W-1:0] in_one, input logic [TIME_W-1:0] in_two,
                             input logic [TIME_W-1:0] out_one, input logic [TIME_W-1:0] out_two);
        apb_write(REG_ENTRY_ONE, in_one);
        apb_write(REG_ENTRY_TWO, in_two);
        apb_write(REG_EXIT_ONE, out_one);
        apb_write(REG_EXIT_TWO, out_two);
    endtask

    // Sends the whole plan in bursts; must be entered at a falling edge.
    task automatic send_plan();
        station_item_t item;
        int            burst_left;
        int            gap;
        burst_left = 0;
        while (station_plan.size() > 0) begin
            item = station_plan.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    station_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            station_ch.valid             <= 1'b1;
            station_ch.station_time_one  <= item.time_one;
            station_ch.station_time_two  <= item.time_two;
            station_ch.transfer_from_one <= item.xfer_one;
            station_ch.transfer_from_two <= item.xfer_two;
            station_ch.last_station      <= item.last;
            do @(posedge clk); while (!station_ch.ready);
            burst_left--;
            @(negedge clk);
        end
        station_ch.valid <= 1'b0;
    endtask

    // Every run ends on a final station, so once the results are in, the
    // block has already cleared its run state.
    task automatic settle();
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Result port: random duty that is redrawn whenever its span runs out, plus one long
    // hold-off on request so the block backs up into its station input.
    initial begin
        int duty;
        int span;
        result_ch.ready = 1'b0;
        duty            = 100;
        span            = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (span == 0) begin
                case ($urandom_range(0, 3))
                    0:       duty = 100;
                    1:       duty = 75;
                    2:       duty = 40;
                    default: duty = 10;
                endcase
                span = 50;
            end
            span--;
            result_ch.ready <= ($urandom_range(1, 100) <= duty);
        end
    end

    initial begin
        int planned;
        int count;
        int phase;
        rst_n                        = 1'b0;
        psel                         = 1'b0;
        penable                      = 1'b0;
        pwrite                       = 1'b0;
        paddr                        = '0;
        pwdata                       = '0;
        hold_off_request             = 1'b0;
        station_ch.valid             = 1'b0;
        station_ch.station_time_one  = '0;
        station_ch.station_time_two  = '0;
        station_ch.transfer_from_one = '0;
        station_ch.transfer_from_two = '0;
        station_ch.last_station      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default costs: single-station runs at both extremes, then a short
        // run that is pushed across lines by cheap and costly transfers.
        push_station('0, '0, '0, '0, 1'b1);
        push_station(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 1'b1);
        push_station(TIME_MAX, '0, '0, TIME_MAX, 1'b0);
        push_station('0, TIME_MAX, TIME_MAX, '0, 1'b0);
        push_station(12'd100, 12'd200, '0, '0, 1'b1);
        send_plan();
        settle();

        // All costs zero: an extreme run, then one where every compare and exit tie.
        set_costs('0, '0, '0, '0);
        plan_run(4, MIX_EXTREME);
        push_station('0, '0, '0, '0, 1'b0);
        push_station(12'd5, 12'd5, '0, '0, 1'b0);
        push_station(12'd5, 12'd5, '0, '0, 1'b1);
        send_plan();
        settle();

        set_costs(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
        plan_run(2, MIX_EXTREME);
        plan_run(5, MIX_EXTREME);
        send_plan();
        settle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                1:       set_costs('0, TIME_MAX, TIME_MAX, '0);
                2:       set_costs(TIME_MAX, '0, '0, TIME_MAX);
                3:       set_costs(TIME_W'($urandom_range(0, 15)), TIME_W'($urandom_range(0, 15)),
                                   TIME_W'($urandom_range(0, 15)), TIME_W'($urandom_range(0, 15)));
                default: set_costs(pick_value(MIX_FULL), pick_value(MIX_FULL),
                                   pick_value(MIX_FULL), pick_value(MIX_FULL));
            endcase
            planned = 0;
            while (planned < 8) begin
                count = $urandom_range(1, 8);
                if ($urandom_range(0, 7) == 0)
                    count = $urandom_range(9, 30);
                plan_run(count, value_mix_t'($urandom_range(0, 3)));
                planned += count;
            end
            if (phase == 2)
                hold_off_request = 1'b1;
            send_plan();
            settle();
        end

        // A run that exactly fills the store.
        set_costs(pick_value(MIX_FULL), pick_value(MIX_FULL),
                  pick_value(MIX_FULL), pick_value(MIX_FULL));
        plan_run(MAX_STATIONS, MIX_FULL);
        send_plan();
        settle();

        // Another run that exactly fills the store, on high station values, then
        // a short run on small ones; neither sets the overflow flag.
        set_costs(TIME_MAX, pick_value(MIX_FULL), pick_value(MIX_FULL), TIME_MAX);
        plan_run(MAX_STATIONS, MIX_HIGH);
        plan_run(3, MIX_SMALL);
        send_plan();
        settle();

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> assembly_line_scheduler.f
rtl/als_pkg.sv
rtl/als_if.sv
rtl/als_alu.sv
rtl/assembly_line_scheduler.sv
rtl/als_checker.sv
tb/als_checker.sv
tb/testbench.sv
